// File: hw/rtl/ccts_pkg.sv
// Shared types and constants for the cycle counter time split block.
`timescale 1ns / 1ps

package ccts_pkg;

    localparam int unsigned MHZ_W   = 10;  // clock frequency register width
    localparam int unsigned DIV_W   = 30;  // divisor / remainder width (1023e6 < 2^30)
    localparam int unsigned DVD_W   = 64;  // dividend and quotient width
    localparam int unsigned STEP_W  = 7;   // step counter width, holds SEC_STEPS
    localparam int unsigned SUB_W   = 10;  // quotient bits of the ms and us passes
    localparam int unsigned SECS_W  = 45;

    localparam logic [STEP_W-1:0] SEC_STEPS = 7'd64;
    localparam logic [STEP_W-1:0] SUB_STEPS = 7'd10;

    localparam logic [19:0]      HZ_PER_MHZ  = 20'd1000000;
    localparam logic [9:0]       KHZ_PER_MHZ = 10'd1000;
    localparam logic [MHZ_W-1:0] CLOCK_RESET = 10'd168;

    // Command to the shared divider, valid in the cycle start is high.
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  divisor;
        logic [DIV_W-1:0]  partial;   // initial partial remainder, below divisor
        logic [DVD_W-1:0]  dividend;  // bits consumed MSB first
        logic [STEP_W-1:0] steps;
    } t_div_cmd;

    // Divider status back to the sequencer.
    typedef struct packed {
        logic             step;      // one quotient bit resolved this cycle
        logic             qbit;      // that bit
        logic             done;      // quotient and remainder final
        logic [DVD_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_stat;

endpackage

// File: hw/rtl/ccts_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ccts_divider
    import ccts_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_cmd  i_cmd,
    output t_div_stat o_stat
);

    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_div;
    logic [DVD_W-1:0]  r_dvd;   // dividend shifts out on top, quotient shifts in below
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DIV_W:0]   n_trial;
    logic             n_ge;
    logic [DIV_W:0]   n_diff;
    logic [DIV_W-1:0] n_rem;

    always_comb begin
        n_trial = {r_rem, r_dvd[DVD_W-1]};
        n_ge    = (n_trial >= {1'b0, r_div});
        n_diff  = n_trial - {1'b0, r_div};
        n_rem   = n_ge ? n_diff[DIV_W-1:0] : n_trial[DIV_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_rem  <= i_cmd.partial;
                r_div  <= i_cmd.divisor;
                r_dvd  <= i_cmd.dividend;
                r_cnt  <= i_cmd.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[DVD_W-2:0], n_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.step      = r_busy;
    assign o_stat.qbit      = n_ge;
    assign o_stat.done      = r_done;
    assign o_stat.quotient  = r_dvd;
    assign o_stat.remainder = r_rem;

endmodule

// File: hw/rtl/cycle_counter_time_split.sv
// Top level: cycle counter extension to 64 bits and split into seconds, ms and us.
// Sequence per request: load, then the shared divider resolves the seconds
//   (64 quotient bits), then the ms and us parts (10 bits each), then finish.
// Throughput: one request at a time; the next can be taken in the cycle after
//   the result is accepted.
// Reset (i_rst_n, synchronous, active low): clears wrap count, last sample and
//   sequencer; clock_mhz returns to 168.
`timescale 1ns / 1ps

module cycle_counter_time_split
    import ccts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_we,
    input  logic [MHZ_W-1:0]  i_cfg_wdata,
    // request channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [31:0]       i_counter_sample,
    input  logic [31:0]       i_previous_sample,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic [63:0]       o_total_cycles,
    output logic [SECS_W-1:0] o_whole_seconds,
    output logic [9:0]        o_millis_part,
    output logic [9:0]        o_micros_part,
    output logic [63:0]       o_total_micros,
    output logic [31:0]       o_delta_cycles
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SEC_GO,
        S_SEC_RUN,
        S_MS_GO,
        S_MS_RUN,
        S_US_GO,
        S_US_RUN,
        S_FIN,
        S_OUT
    } t_state;

    t_state r_state;

    logic [MHZ_W-1:0]  r_clock_mhz;
    logic [31:0]       r_wrap;
    logic [31:0]       r_last;

    logic [MHZ_W-1:0]  r_mhz;      // effective clock, zero read as 1 MHz
    logic [DIV_W-1:0]  r_hz;
    logic [DIV_W-1:0]  r_per_ms;
    logic [63:0]       r_total;
    logic [31:0]       r_delta;
    logic [63:0]       r_acc;      // secs * 1e6, built MSB first from quotient bits
    logic [SECS_W-1:0] r_secs;
    logic [SUB_W-1:0]  r_ms;
    logic [SUB_W-1:0]  r_us;
    logic [63:0]       r_micros;

    logic              n_accept;
    logic [31:0]       n_wrap;
    logic [19:0]       n_ms_scaled;

    t_div_cmd  div_cmd;
    t_div_stat div_stat;

    ccts_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (div_cmd),
        .o_stat  (div_stat)
    );

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign n_accept = i_valid && o_ready;

    // A sample below the last one means the hardware counter wrapped.
    assign n_wrap = (i_counter_sample < r_last) ? r_wrap + 32'd1 : r_wrap;

    assign n_ms_scaled = {10'd0, r_ms} * {10'd0, KHZ_PER_MHZ};

    // Divider commands. The ms and us passes resolve only 10 quotient bits:
    // the remainder is below divisor * 1024, so its top part already sits
    // below the divisor and seeds the partial remainder.
    always_comb begin
        div_cmd          = '0;
        div_cmd.dividend = {div_stat.remainder[SUB_W-1:0], {(DVD_W-SUB_W){1'b0}}};
        div_cmd.partial  = {{SUB_W{1'b0}}, div_stat.remainder[DIV_W-1:SUB_W]};
        div_cmd.steps    = SUB_STEPS;
        case (r_state)
            S_SEC_GO: begin
                div_cmd.start    = 1'b1;
                div_cmd.divisor  = r_hz;
                div_cmd.partial  = '0;
                div_cmd.dividend = r_total;
                div_cmd.steps    = SEC_STEPS;
            end
            S_MS_GO: begin
                div_cmd.start   = 1'b1;
                div_cmd.divisor = r_per_ms;
            end
            S_US_GO: begin
                div_cmd.start   = 1'b1;
                div_cmd.divisor = {{(DIV_W-MHZ_W){1'b0}}, r_mhz};
            end
            default: begin
                div_cmd.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clock_mhz <= CLOCK_RESET;
            r_wrap      <= '0;
            r_last      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_clock_mhz <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_wrap  <= n_wrap;
                        r_last  <= i_counter_sample;
                        r_total <= {n_wrap, i_counter_sample};
                        r_delta <= i_counter_sample - i_previous_sample;
                        r_mhz   <= (r_clock_mhz == '0) ? 10'd1 : r_clock_mhz;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_hz     <= {{(DIV_W-MHZ_W){1'b0}}, r_mhz} * {10'd0, HZ_PER_MHZ};
                    r_per_ms <= {{(DIV_W-MHZ_W){1'b0}}, r_mhz} * {20'd0, KHZ_PER_MHZ};
                    r_state  <= S_SEC_GO;
                end
                S_SEC_GO: begin
                    r_acc   <= '0;
                    r_state <= S_SEC_RUN;
                end
                S_SEC_RUN: begin
                    // Horner form: acc = 2*acc + qbit*1e6 per quotient bit
                    if (div_stat.step) begin
                        r_acc <= {r_acc[62:0], 1'b0}
                                 + (div_stat.qbit ? {44'd0, HZ_PER_MHZ} : 64'd0);
                    end
                    if (div_stat.done) begin
                        r_secs  <= div_stat.quotient[SECS_W-1:0];
                        r_state <= S_MS_GO;
                    end
                end
                S_MS_GO: begin
                    r_state <= S_MS_RUN;
                end
                S_MS_RUN: begin
                    if (div_stat.done) begin
                        r_ms    <= div_stat.quotient[SUB_W-1:0];
                        r_state <= S_US_GO;
                    end
                end
                S_US_GO: begin
                    r_state <= S_US_RUN;
                end
                S_US_RUN: begin
                    if (div_stat.done) begin
                        r_us    <= div_stat.quotient[SUB_W-1:0];
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_micros <= r_acc + {44'd0, n_ms_scaled} + {54'd0, r_us};
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_total_cycles  = r_total;
    assign o_whole_seconds = r_secs;
    assign o_millis_part   = r_ms;
    assign o_micros_part   = r_us;
    assign o_total_micros  = r_micros;
    assign o_delta_cycles  = r_delta;

endmodule

// File: tb/cycle_counter_time_split_tb.sv
// Testbench for cycle_counter_time_split: self-checking run with a built-in timebase tracker.
`timescale 1ns / 1ps

module cycle_counter_time_split_tb
    import ccts_pkg::*;
;

    localparam int unsigned ITEMS_PER_CHUNK = 107;  // random requests per clock setting
    localparam int unsigned CHUNKS          = 5;    // clock settings per idling phase
    localparam int unsigned HOLD_CYCLES     = 1200; // long result-side hold-off
    localparam int unsigned TAIL_CYCLES     = 200;  // quiet time after the last result

    // One result as the block reports it.
    typedef struct {
        logic [63:0]       total_cycles;
        logic [SECS_W-1:0] whole_seconds;
        logic [9:0]        millis_part;
        logic [9:0]        micros_part;
        logic [63:0]       total_micros;
        logic [31:0]       delta_cycles;
    } t_split;

    // Tracks wrap count, last sample and clock setting, and queues the time
    // split that each accepted request must produce.
    class timebase_tracker;
        logic [MHZ_W-1:0] clock_mhz;
        logic [31:0]      wrap_count;
        logic [31:0]      last_sample;
        t_split           expected_splits[$];
        int unsigned      mismatches;
        int unsigned      splits_checked;
        int unsigned      wraps_seen;

        function new();
            clock_mhz   = CLOCK_RESET;
            wrap_count  = '0;
            last_sample = '0;
        endfunction

        function void set_clock(logic [MHZ_W-1:0] mhz);
            clock_mhz = mhz;
        endfunction

        function void note_request(logic [31:0] smp, logic [31:0] prv);
            t_split      e;
            logic [63:0] mhz, hz, per_ms, secs, rem, ms, us;
            // zero setting runs as 1 MHz
            mhz    = (clock_mhz == '0) ? 64'd1 : 64'(clock_mhz);
            hz     = mhz * 64'(HZ_PER_MHZ);
            per_ms = mhz * 64'(KHZ_PER_MHZ);
            // strictly smaller sample means the counter wrapped
            if (smp < last_sample) begin
                wrap_count = wrap_count + 32'd1;
                wraps_seen++;
            end
            last_sample = smp;
            e.total_cycles  = {wrap_count, smp};
            secs            = e.total_cycles / hz;
            rem             = e.total_cycles - secs * hz;
            ms              = rem / per_ms;
            rem             = rem - ms * per_ms;
            us              = rem / mhz;
            e.whole_seconds = secs[SECS_W-1:0];
            e.millis_part   = ms[9:0];
            e.micros_part   = us[9:0];
            e.total_micros  = secs * 64'(HZ_PER_MHZ) + ms * 64'(KHZ_PER_MHZ) + us;
            e.delta_cycles  = smp - prv;
            expected_splits.push_back(e);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_result(t_split got);
            t_split want;
            if (expected_splits.size() == 0) begin
                report_mismatch("result with no request outstanding");
                return;
            end
            want = expected_splits.pop_front();
            splits_checked++;
            if (got.total_cycles !== want.total_cycles)
                report_mismatch($sformatf("total_cycles %h, want %h",
                                          got.total_cycles, want.total_cycles));
            if (got.whole_seconds !== want.whole_seconds)
                report_mismatch($sformatf("whole_seconds %0d, want %0d",
                                          got.whole_seconds, want.whole_seconds));
            if (got.millis_part !== want.millis_part)
                report_mismatch($sformatf("millis_part %0d, want %0d",
                                          got.millis_part, want.millis_part));
            if (got.micros_part !== want.micros_part)
                report_mismatch($sformatf("micros_part %0d, want %0d",
                                          got.micros_part, want.micros_part));
            if (got.total_micros !== want.total_micros)
                report_mismatch($sformatf("total_micros %0d, want %0d",
                                          got.total_micros, want.total_micros));
            if (got.delta_cycles !== want.delta_cycles)
                report_mismatch($sformatf("delta_cycles %h, want %h",
                                          got.delta_cycles, want.delta_cycles));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [MHZ_W-1:0]  i_cfg_wdata;
    logic              i_valid;
    logic              o_ready;
    logic [31:0]       i_counter_sample;
    logic [31:0]       i_previous_sample;
    logic              o_valid;
    logic              i_ready;
    logic [63:0]       o_total_cycles;
    logic [SECS_W-1:0] o_whole_seconds;
    logic [9:0]        o_millis_part;
    logic [9:0]        o_micros_part;
    logic [63:0]       o_total_micros;
    logic [31:0]       o_delta_cycles;

    timebase_tracker book;

    // idling odds in percent, changed per phase by the main sequence
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_off_req;      // main asks the result side for a long hold-off
    int unsigned requests_sent;
    int unsigned clock_writes;

    cycle_counter_time_split dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_counter_sample  (i_counter_sample),
        .i_previous_sample (i_previous_sample),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_total_cycles    (o_total_cycles),
        .o_whole_seconds   (o_whole_seconds),
        .o_millis_part     (o_millis_part),
        .o_micros_part     (o_micros_part),
        .o_total_micros    (o_total_micros),
        .o_delta_cycles    (o_delta_cycles)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one request after a random gap. Valid is left high on return; the
    // next call either keeps it high with a new payload or drops it for a gap,
    // so valid never sees two writes in one step.
    task automatic send_request(input logic [31:0] smp, input logic [31:0] prv);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_counter_sample  <= smp;
        i_previous_sample <= prv;
        // sampled values are the ones seen at the edge
        do @(posedge i_clk); while (!o_ready);
        book.note_request(smp, prv);
        requests_sent++;
    endtask

    // Drop valid in the step of the last handshake and wait for every result.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (book.expected_splits.size() != 0) @(posedge i_clk);
    endtask

    // Clock register is only written with the block idle.
    task automatic write_clock(input logic [MHZ_W-1:0] mhz);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mhz;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        book.set_clock(mhz);
        clock_writes++;
    endtask

    // Result side: check each accepted result, then pick ready for the next edge.
    initial begin : result_sink
        t_split      got;
        int unsigned hold_left;
        hold_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.total_cycles  = o_total_cycles;
                got.whole_seconds = o_whole_seconds;
                got.millis_part   = o_millis_part;
                got.micros_part   = o_micros_part;
                got.total_micros  = o_total_micros;
                got.delta_cycles  = o_delta_cycles;
                book.check_result(got);
            end
            if (hold_off_req) begin
                hold_left    = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (!i_rst_n) begin
                i_ready <= 1'b0;
            end else if (hold_left != 0) begin
                i_ready <= 1'b0;
                hold_left--;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Main sequence: reset, directed corners, then three idling phases of random
    // requests with a fresh clock setting for every chunk.
    initial begin : main_seq
        logic [31:0]      cur, prv, last_sent;
        logic [MHZ_W-1:0] mhz;
        int unsigned      kind, pk, ck;
        book          = new();
        send_idle_pct = 38;
        recv_idle_pct = 86;
        hold_off_req  = 1'b0;
        requests_sent = 0;
        clock_writes  = 0;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= '0;
        i_valid           <= 1'b0;
        i_counter_sample  <= '0;
        i_previous_sample <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset clock of 168 MHz; equal-to-zero first sample is no wrap
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);  // equal sample, no wrap
        send_request(32'h0000_0000, 32'hFFFF_FFFF);  // wrap, delta of one
        send_request(32'h0000_0000, 32'h0000_0000);
        send_request(32'h0000_0001, 32'h0000_0002);  // delta wraps below zero
        send_request(32'h8000_0000, 32'h7FFF_FFFF);
        // slowest legal clock, 1 MHz; samples around one million
        write_clock(10'd1);
        send_request(32'h0000_0000, 32'h8000_0000);
        send_request(32'd999_999, 32'h0000_0000);
        send_request(32'd1_000_000, 32'd999_999);
        // zero setting runs as 1 MHz
        write_clock(10'd0);
        send_request(32'd12_345_678, 32'd1_000_000);
        send_request(32'd5, 32'd12_345_678);
        // above the nominal range, still used as given
        write_clock(10'd1023);
        send_request(32'hFFFF_FFFF, 32'd5);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        write_clock(10'd1000);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);
        write_clock(10'd1001);
        send_request(32'hDEAD_BEEF, 32'h1234_5678);

        cur       = 32'hDEAD_BEEF;
        last_sent = cur;
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 38; recv_idle_pct = 86; end
                1: begin send_idle_pct = 86; recv_idle_pct = 38; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int chunk = 0; chunk < CHUNKS; chunk++) begin
                // extremes of the clock setting come up often
                ck = $urandom_range(99);
                if (ck < 15)      mhz = 10'd1;
                else if (ck < 30) mhz = 10'd1000;
                else if (ck < 40) mhz = 10'd0;
                else if (ck < 50) mhz = 10'd1023;
                else              mhz = MHZ_W'($urandom_range(1023, 1));
                write_clock(mhz);
                for (int n = 0; n < ITEMS_PER_CHUNK; n++) begin
                    // long result-side hold-off while requests keep coming
                    if (phase == 0 && chunk == 1 && n == 40) hold_off_req = 1'b1;
                    if (phase == 2 && chunk == 2 && n == 30) hold_off_req = 1'b1;
                    // sender pauses until every result is back
                    if (phase == 1 && chunk == 3 && n == 50) drain_results();
                    // mostly a counter moving forward, with wraps, repeats and jumps
                    kind = $urandom_range(99);
                    if (kind < 55)
                        cur = cur + $urandom_range(32'h0010_0000);
                    else if (kind < 70)
                        cur = $urandom;
                    else if (kind < 80)
                        cur = (cur == 0) ? 32'h0 : $urandom_range(cur - 1);
                    else if (kind >= 88 && kind < 94)
                        cur = 32'hFFFF_FFFF - $urandom_range(255);
                    else if (kind >= 94)
                        cur = $urandom_range(255);
                    // kinds 80..87 repeat the sample
                    pk = $urandom_range(99);
                    if (pk < 70)      prv = last_sent;
                    else if (pk < 85) prv = $urandom;
                    else if (pk < 95) prv = cur;
                    else              prv = pk[0] ? 32'hFFFF_FFFF : 32'h0000_0000;
                    send_request(cur, prv);
                    last_sent = cur;
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run covered %0d requests, %0d results checked, %0d clock writes,",
                 requests_sent, book.splits_checked, clock_writes);
        $display("  %0d counter wraps, three idling mixes and two long result hold-offs.",
                 book.wraps_seen);
        if (book.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog, far past the slowest legal run.
    initial begin
        #20_000_000;
        $display("Timeout waiting for the block");
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: cycle_counter_time_split.f
hw/rtl/ccts_pkg.sv
hw/rtl/ccts_divider.sv
hw/rtl/cycle_counter_time_split.sv
tb/cycle_counter_time_split_tb.sv
